/* hw/rtl/waypoint_pursuit_controller_assert.svh */
// assertion shorthands for the waypoint pursuit controller
// both expect clk and rst_n in scope
`ifndef WAYPOINT_PURSUIT_CONTROLLER_ASSERT_SVH
`define WAYPOINT_PURSUIT_CONTROLLER_ASSERT_SVH

// consequent checked in the same cycle
`define WPC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wpc same-cycle check failed");

// consequent checked in the next cycle
`define WPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wpc next-cycle check failed");

`endif

/* hw/rtl/wpc_pkg.sv */
package wpc_pkg;

  localparam int CORDIC_STEPS   = 13;
  localparam int ITER_W         = 4;

  localparam logic signed [15:0] PI_Q12     = 16'sd12868;
  localparam logic signed [15:0] TWO_PI_Q12 = 16'sd25736;

  // action codes
  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_STEP = 2'd1;
  localparam logic [1:0] ACT_SET  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_LINEAR_GAIN       = 3'd0;
  localparam logic [2:0] REG_ANGULAR_GAIN      = 3'd1;
  localparam logic [2:0] REG_MAX_HEADING_ERROR = 3'd2;
  localparam logic [2:0] REG_MAX_LINEAR_SPEED  = 3'd3;
  localparam logic [2:0] REG_MAX_ANGULAR_SPEED = 3'd4;
  localparam logic [2:0] REG_REACH_DISTANCE    = 3'd5;
  localparam logic [2:0] REG_PLAN_LENGTH       = 3'd6;

  typedef struct packed {
    logic [1:0]         action;
    logic [7:0]         entry_index;
    logic signed [15:0] waypoint_x;
    logic signed [15:0] waypoint_y;
  } wpc_in_t;

  typedef struct packed {
    logic signed [15:0] linear_speed;
    logic signed [15:0] angular_speed;
    logic               plan_done;
    logic               waypoint_reached;
    logic [8:0]         waypoint_index;
  } wpc_out_t;

  typedef struct packed {
    logic [15:0] linear_gain;
    logic [15:0] angular_gain;
    logic [13:0] max_heading_error;
    logic [14:0] max_linear_speed;
    logic [14:0] max_angular_speed;
    logic [14:0] reach_distance;
    logic [8:0]  plan_length;
  } wpc_cfg_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_WX,
    MUL_WY,
    MUL_RR,
    MUL_LIN,
    MUL_ANG
  } mul_op_t;

  typedef struct packed {
    logic              load_item;
    logic              mem_write;
    logic              set_index;
    logic              rd_goal;
    logic              cap_point;
    logic              cordic_init;
    logic              cordic_iter;
    logic [ITER_W-1:0] iter;
    logic              norm;
    mul_op_t           mul_op;
    logic              finish;
  } wpc_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       entry_ok;
    logic       plan_done;
  } wpc_sts_t;

  // round(atan(2^-i) * 4096)
  function automatic logic [11:0] atan_q12(input logic [ITER_W-1:0] i);
    logic [11:0] a;
    case (i)
      4'd0:    a = 12'd3217;
      4'd1:    a = 12'd1899;
      4'd2:    a = 12'd1003;
      4'd3:    a = 12'd509;
      4'd4:    a = 12'd256;
      4'd5:    a = 12'd128;
      4'd6:    a = 12'd64;
      4'd7:    a = 12'd32;
      4'd8:    a = 12'd16;
      4'd9:    a = 12'd8;
      4'd10:   a = 12'd4;
      4'd11:   a = 12'd2;
      4'd12:   a = 12'd1;
      default: a = 12'd0;
    endcase
    return a;
  endfunction

endpackage

/* hw/rtl/wpc_cfg_regs.sv */
module wpc_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_wdata,
  output wpc_pkg::wpc_cfg_t cfg
);
  import wpc_pkg::*;

  wpc_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.linear_gain       <= 16'd256;
      cfg_r.angular_gain      <= 16'd256;
      cfg_r.max_heading_error <= 14'd2048;
      cfg_r.max_linear_speed  <= 15'd51;
      cfg_r.max_angular_speed <= 15'd256;
      cfg_r.reach_distance    <= 15'd26;
      cfg_r.plan_length       <= 9'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINEAR_GAIN:       cfg_r.linear_gain       <= cfg_wdata;
        REG_ANGULAR_GAIN:      cfg_r.angular_gain      <= cfg_wdata;
        REG_MAX_HEADING_ERROR: cfg_r.max_heading_error <= cfg_wdata[13:0];
        REG_MAX_LINEAR_SPEED:  cfg_r.max_linear_speed  <= cfg_wdata[14:0];
        REG_MAX_ANGULAR_SPEED: cfg_r.max_angular_speed <= cfg_wdata[14:0];
        REG_REACH_DISTANCE:    cfg_r.reach_distance    <= cfg_wdata[14:0];
        REG_PLAN_LENGTH:       cfg_r.plan_length       <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* hw/rtl/wpc_ctrl.sv */
module wpc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  wpc_pkg::wpc_sts_t sts,
  output wpc_pkg::wpc_cmd_t cmd
);
  import wpc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_RD_CUR,
    S_RD_GOAL,
    S_INIT,
    S_CORDIC,
    S_NORM,
    S_M_WX,
    S_M_WY,
    S_M_RR,
    S_M_LIN,
    S_M_ANG,
    S_FINISH
  } state_t;

  localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_STEPS - 1);

  state_t            state_r, state_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              slot_free;

  always_comb begin
    state_nxt     = state_r;
    iter_nxt      = iter_r;
    cmd           = '0;
    cmd.mul_op    = MUL_NONE;
    cmd.iter      = iter_r;
    slot_free     = !out_valid_r || !out_stall;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.action)
          ACT_LOAD: begin
            cmd.mem_write = sts.entry_ok;
            state_nxt     = S_IDLE;
          end
          ACT_SET: begin
            cmd.set_index = 1'b1;
            state_nxt     = S_IDLE;
          end
          ACT_STEP: begin
            state_nxt = sts.plan_done ? S_FINISH : S_RD_CUR;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_RD_CUR:  state_nxt = S_RD_GOAL;
      S_RD_GOAL: begin
        // current waypoint is on the read port, goal address goes out
        cmd.rd_goal   = 1'b1;
        cmd.cap_point = 1'b1;
        state_nxt     = S_INIT;
      end
      S_INIT: begin
        cmd.cordic_init = 1'b1;
        iter_nxt        = '0;
        state_nxt       = S_CORDIC;
      end
      S_CORDIC: begin
        cmd.cordic_iter = 1'b1;
        if (iter_r == LAST_ITER) begin
          state_nxt = S_NORM;
        end else begin
          iter_nxt = iter_r + 1'b1;
        end
      end
      S_NORM: begin
        cmd.norm  = 1'b1;
        state_nxt = S_M_WX;
      end
      S_M_WX: begin
        cmd.mul_op = MUL_WX;
        state_nxt  = S_M_WY;
      end
      S_M_WY: begin
        cmd.mul_op = MUL_WY;
        state_nxt  = S_M_RR;
      end
      S_M_RR: begin
        cmd.mul_op = MUL_RR;
        state_nxt  = S_M_LIN;
      end
      S_M_LIN: begin
        cmd.mul_op = MUL_LIN;
        state_nxt  = S_M_ANG;
      end
      S_M_ANG: begin
        cmd.mul_op = MUL_ANG;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        // hold here while the previous word still sits in the output register
        if (slot_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* hw/rtl/wpc_dpath.sv */
module wpc_dpath #(
  parameter int MAX_WAYPOINTS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  wpc_pkg::wpc_in_t  in_data,
  input  wpc_pkg::wpc_cfg_t cfg,
  input  wpc_pkg::wpc_cmd_t cmd,
  output wpc_pkg::wpc_sts_t sts,
  output wpc_pkg::wpc_out_t out_data
);
  import wpc_pkg::*;

  localparam int AW  = $clog2(MAX_WAYPOINTS);
  localparam int LW  = $clog2(MAX_WAYPOINTS + 1);
  localparam int CW  = (LW > 9) ? LW : 9;
  localparam int CDW = 20;

  wpc_in_t            item_r;
  logic [8:0]         cur_idx_r;
  logic signed [15:0] mem_x [MAX_WAYPOINTS];
  logic signed [15:0] mem_y [MAX_WAYPOINTS];
  logic signed [15:0] rd_x_r, rd_y_r;
  logic signed [15:0] wx_r, wy_r, gx_r, h_r;
  logic signed [CDW-1:0] cx_r, cy_r;
  logic signed [15:0] cz_r;
  logic               zero_r;
  logic signed [33:0] prod_r;
  mul_op_t            last_op_r;
  logic [31:0]        d2_r;
  logic               reach_r;
  logic signed [15:0] lin_r;
  wpc_out_t           out_r;

  logic [CW-1:0]      max_c, plen_ext, len, cur_ext, entry_ext, goal_ext;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               plan_done;
  logic signed [CDW-1:0] wx_e, wy_e, xs, ys;
  logic signed [15:0] step_ang;
  logic [13:0]        h_abs;
  logic signed [16:0] ma, mb;
  logic signed [33:0] ps, c, c_abs, neg_c, max_l34, max_a34;
  logic signed [15:0] lin_clip, ang_c;

  // plan length limited to the store depth
  assign max_c     = CW'(MAX_WAYPOINTS);
  assign plen_ext  = CW'(cfg.plan_length);
  assign len       = (plen_ext > max_c) ? max_c : plen_ext;
  assign cur_ext   = CW'(cur_idx_r);
  assign entry_ext = CW'(item_r.entry_index);
  assign goal_ext  = len - 1'b1;
  assign plan_done = (cur_ext >= len);
  assign rd_addr   = cmd.rd_goal ? goal_ext[AW-1:0] : cur_ext[AW-1:0];
  assign wr_addr   = entry_ext[AW-1:0];

  assign sts.action    = item_r.action;
  assign sts.entry_ok  = (entry_ext < max_c);
  assign sts.plan_done = plan_done;

  always_ff @(posedge clk) begin
    if (cmd.mem_write) begin
      mem_x[wr_addr] <= item_r.waypoint_x;
      mem_y[wr_addr] <= item_r.waypoint_y;
    end
    rd_x_r <= mem_x[rd_addr];
    rd_y_r <= mem_y[rd_addr];
  end

  // cordic vectoring step
  assign wx_e     = {{(CDW-16){wx_r[15]}}, wx_r};
  assign wy_e     = {{(CDW-16){wy_r[15]}}, wy_r};
  assign xs       = cx_r >>> cmd.iter;
  assign ys       = cy_r >>> cmd.iter;
  assign step_ang = $signed({4'd0, atan_q12(cmd.iter)});
  assign h_abs    = h_r[15] ? 14'(-h_r) : h_r[13:0];

  // shared multiplier operands
  always_comb begin
    case (cmd.mul_op)
      MUL_WX: begin
        ma = {wx_r[15], wx_r};
        mb = {wx_r[15], wx_r};
      end
      MUL_WY: begin
        ma = {wy_r[15], wy_r};
        mb = {wy_r[15], wy_r};
      end
      MUL_RR: begin
        ma = $signed({2'b00, cfg.reach_distance});
        mb = $signed({2'b00, cfg.reach_distance});
      end
      MUL_LIN: begin
        ma = {gx_r[15], gx_r};
        mb = $signed({1'b0, cfg.linear_gain});
      end
      MUL_ANG: begin
        ma = {h_r[15], h_r};
        mb = $signed({1'b0, cfg.angular_gain});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // linear clip: above only, then at the field floor
  always_comb begin
    ps      = prod_r >>> 8;
    max_l34 = $signed({19'd0, cfg.max_linear_speed});
    if (ps >= max_l34) begin
      lin_clip = $signed({1'b0, cfg.max_linear_speed});
    end else if (ps < -34'sd32768) begin
      lin_clip = 16'sh8000;
    end else begin
      lin_clip = ps[15:0];
    end
  end

  // angular clip, product already holds heading times gain
  always_comb begin
    c       = prod_r >>> 12;
    c_abs   = c[33] ? -c : c;
    neg_c   = -c;
    max_a34 = $signed({19'd0, cfg.max_angular_speed});
    if (c_abs < max_a34) begin
      ang_c = neg_c[15:0];
    end else if (c > 34'sd0) begin
      ang_c = -$signed({1'b0, cfg.max_angular_speed});
    end else begin
      ang_c = $signed({1'b0, cfg.max_angular_speed});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_idx_r <= '0;
      last_op_r <= MUL_NONE;
    end else begin
      last_op_r <= cmd.mul_op;
      if (cmd.set_index) begin
        cur_idx_r <= {1'b0, item_r.entry_index};
      end else if (cmd.finish && !plan_done) begin
        cur_idx_r <= cur_idx_r + 9'(reach_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    if (cmd.cap_point) begin
      wx_r <= rd_x_r;
      wy_r <= rd_y_r;
    end
    if (cmd.cordic_init) begin
      gx_r   <= rd_x_r;
      zero_r <= (wx_r == 16'sd0) && (wy_r == 16'sd0);
      if (wx_r < 16'sd0) begin
        cx_r <= -wx_e;
        cy_r <= -wy_e;
        cz_r <= (wy_r >= 16'sd0) ? PI_Q12 : -PI_Q12;
      end else begin
        cx_r <= wx_e;
        cy_r <= wy_e;
        cz_r <= 16'sd0;
      end
    end
    if (cmd.cordic_iter) begin
      if (!cy_r[CDW-1]) begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + step_ang;
      end else begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - step_ang;
      end
    end
    if (cmd.norm) begin
      if (zero_r) begin
        h_r <= 16'sd0;
      end else if (cz_r > PI_Q12) begin
        h_r <= cz_r - TWO_PI_Q12;
      end else if (cz_r < -PI_Q12) begin
        h_r <= cz_r + TWO_PI_Q12;
      end else begin
        h_r <= cz_r;
      end
    end
    if (cmd.mul_op != MUL_NONE) begin
      prod_r <= ma * mb;
    end
    // consume the product issued in the previous cycle
    case (last_op_r)
      MUL_WX:  d2_r    <= prod_r[31:0];
      MUL_WY:  d2_r    <= d2_r + prod_r[31:0];
      MUL_RR:  reach_r <= (d2_r < prod_r[31:0]);
      MUL_LIN: lin_r   <= (h_abs <= cfg.max_heading_error) ? lin_clip : 16'sd0;
      default: ;
    endcase
    if (cmd.finish) begin
      if (plan_done) begin
        out_r.linear_speed     <= 16'sd0;
        out_r.angular_speed    <= 16'sd0;
        out_r.plan_done        <= 1'b1;
        out_r.waypoint_reached <= 1'b0;
        out_r.waypoint_index   <= cur_idx_r;
      end else begin
        out_r.linear_speed     <= lin_r;
        out_r.angular_speed    <= ang_c;
        out_r.plan_done        <= 1'b0;
        out_r.waypoint_reached <= reach_r;
        out_r.waypoint_index   <= cur_idx_r + 9'(reach_r);
      end
    end
  end

  assign out_data = out_r;

endmodule

/* hw/rtl/waypoint_pursuit_controller.sv */
// channel | ports                          | word
// input   | in_valid, in_stall, in_data    | wpc_in_t: action, entry, waypoint x/y
// result  | out_valid, out_stall, out_data | wpc_out_t: speeds, done, reached, index
// config  | cfg_we, cfg_index, cfg_wdata   | one register per write, no read-back
//
// load, set and unused actions: accept, decode; a step past the plan adds a result
// an active step runs accept, decode, two plan store reads, cordic
// setup, 13 cordic iterations, normalize, 5 passes of the shared multiplier, result
// reset presets config, clears current index and control; plan store keeps its data
// a result waits in the output register while the next word is accepted; a step
// holds in its last cycle until that register is free
module waypoint_pursuit_controller #(
  parameter int MAX_WAYPOINTS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  wpc_pkg::wpc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output wpc_pkg::wpc_out_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_wdata
);
  import wpc_pkg::*;

  wpc_cfg_t cfg;
  wpc_cmd_t cmd;
  wpc_sts_t sts;

  wpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  wpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  wpc_dpath #(
    .MAX_WAYPOINTS (MAX_WAYPOINTS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg      (cfg),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

/* hw/rtl/wpc_port_check.sv */
`include "waypoint_pursuit_controller_assert.svh"

module wpc_port_check (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input wpc_pkg::wpc_out_t out_data
);
  import wpc_pkg::*;

  // held result word stays put
  `WPC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // one word in work at a time
  `WPC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // a result only appears from a word in work
  `WPC_ASSERT_SAME(a_result_from_work, $rose(out_valid), $past(in_stall))

  // a finished plan gives no drive and no advance
  `WPC_ASSERT_SAME(a_done_quiet, out_valid && out_data.plan_done, out_data.linear_speed == 16'sd0 && out_data.angular_speed == 16'sd0 && !out_data.waypoint_reached)

endmodule

bind waypoint_pursuit_controller wpc_port_check u_port_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* verif/tb_waypoint_pursuit_controller.sv */
module tb_waypoint_pursuit_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import wpc_pkg::*;

  localparam int MAX_WP = 256;
  localparam int HALF_TURN = 12868;
  localparam int FULL_TURN = 25736;
  localparam int BEARING_STEPS = 13;
  localparam int PHASES = 9;
  localparam int ITEMS_PER_PHASE = 12;
  localparam int LONG_HOLD = 400;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  wpc_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  wpc_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  // stimulus side
  wpc_in_t pending_words[$];
  int      words_queued = 0;
  int      words_taken = 0;
  bit      plan_written[MAX_WP];
  int      send_idle_pct = 14;
  int      recv_stall_pct = 84;
  bit      hold_flip = 1'b0;
  bit      hold_seen = 1'b0;
  int      hold_left = 0;

  // predictor state
  wpc_cfg_t          cfg_shadow = '{16'd256, 16'd256, 14'd2048, 15'd51, 15'd256, 15'd26, 9'd0};
  logic signed [15:0] plan_x_mem[MAX_WP];
  logic signed [15:0] plan_y_mem[MAX_WP];
  logic [8:0]         cur_wp = '0;
  wpc_out_t           drive_cmds_due[$];

  int fail_count = 0;
  int cycle_count = 0;

  waypoint_pursuit_controller #(
    .MAX_WAYPOINTS(MAX_WP)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= 100) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
  endtask

  // vectoring cordic, q3.12 radians, folded into [-pi, pi]
  function automatic int cordic_bearing(input int px, input int py);
    int vx, vy, ang, base, sx, sy;
    vx = px;
    vy = py;
    ang = 0;
    base = 0;
    if (px == 0 && py == 0) return 0;
    if (vx < 0) begin
      base = (vy >= 0) ? HALF_TURN : -HALF_TURN;
      vx = -vx;
      vy = -vy;
    end
    for (int i = 0; i < BEARING_STEPS; i++) begin
      sx = vx >>> i;
      sy = vy >>> i;
      if (vy >= 0) begin
        vx = vx + sy;
        vy = vy - sx;
        ang = ang + int'($atan(1.0 / (2.0 ** i)) * 4096.0);
      end else begin
        vx = vx - sy;
        vy = vy + sx;
        ang = ang - int'($atan(1.0 / (2.0 ** i)) * 4096.0);
      end
    end
    ang = ang + base;
    if (ang > HALF_TURN) ang = ang - FULL_TURN;
    else if (ang < -HALF_TURN) ang = ang + FULL_TURN;
    return ang;
  endfunction

  task automatic predict_word(input wpc_in_t w);
    wpc_out_t res;
    int       len, wx, wy, gx, h, herr;
    longint   lin, ang, c, d2, rr, mas;
    res = '0;
    len = (int'(cfg_shadow.plan_length) > MAX_WP) ? MAX_WP : int'(cfg_shadow.plan_length);
    case (w.action)
      ACT_LOAD: begin
        plan_x_mem[w.entry_index] = w.waypoint_x;
        plan_y_mem[w.entry_index] = w.waypoint_y;
      end
      ACT_SET: cur_wp = {1'b0, w.entry_index};
      ACT_STEP: begin
        if (int'(cur_wp) >= len) begin
          res.plan_done = 1'b1;
          res.waypoint_index = cur_wp;
        end else begin
          wx = plan_x_mem[cur_wp];
          wy = plan_y_mem[cur_wp];
          gx = plan_x_mem[len - 1];
          h = cordic_bearing(wx, wy);
          herr = (h < 0) ? -h : h;
          lin = 0;
          if (herr <= int'(cfg_shadow.max_heading_error)) begin
            lin = (longint'(gx) * longint'(cfg_shadow.linear_gain)) >>> 8;
            if (lin >= longint'(cfg_shadow.max_linear_speed))
              lin = longint'(cfg_shadow.max_linear_speed);
            if (lin < -32768) lin = -32768;
          end
          mas = longint'(cfg_shadow.max_angular_speed);
          c = (longint'(h) * longint'(cfg_shadow.angular_gain)) >>> 12;
          if (((c < 0) ? -c : c) < mas) ang = -c;
          else ang = (c > 0) ? -mas : mas;
          d2 = longint'(wx) * wx + longint'(wy) * wy;
          rr = longint'(cfg_shadow.reach_distance) * longint'(cfg_shadow.reach_distance);
          if (d2 < rr) begin
            res.waypoint_reached = 1'b1;
            cur_wp = cur_wp + 9'd1;
          end
          res.linear_speed = 16'(lin);
          res.angular_speed = 16'(ang);
          res.waypoint_index = cur_wp;
        end
        drive_cmds_due.push_back(res);
      end
      default: ;
    endcase
  endtask

  // sender: hold the word until taken, then maybe idle
  always @(posedge clk) begin : send_words
    logic    nxt_valid;
    wpc_in_t nxt_word;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      nxt_word = in_data;
      if (in_valid && !in_stall) begin
        predict_word(in_data);
        words_taken++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_words.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        nxt_word = pending_words.pop_front();
        nxt_valid = 1'b1;
      end
      in_valid <= nxt_valid;
      in_data <= nxt_word;
    end
  end

  always @(posedge clk) begin : take_results
    wpc_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (drive_cmds_due.size() == 0) begin
          log_failure($sformatf("result word %h with nothing expected", out_data));
        end else begin
          want = drive_cmds_due.pop_front();
          if (out_data.linear_speed !== want.linear_speed)
            log_failure($sformatf("linear_speed got %0d expected %0d",
                                  out_data.linear_speed, want.linear_speed));
          if (out_data.angular_speed !== want.angular_speed)
            log_failure($sformatf("angular_speed got %0d expected %0d",
                                  out_data.angular_speed, want.angular_speed));
          if (out_data.plan_done !== want.plan_done)
            log_failure($sformatf("plan_done got %0d expected %0d",
                                  out_data.plan_done, want.plan_done));
          if (out_data.waypoint_reached !== want.waypoint_reached)
            log_failure($sformatf("waypoint_reached got %0d expected %0d",
                                  out_data.waypoint_reached, want.waypoint_reached));
          if (out_data.waypoint_index !== want.waypoint_index)
            log_failure($sformatf("waypoint_index got %0d expected %0d",
                                  out_data.waypoint_index, want.waypoint_index));
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // long receiver hold-off, started by a flip from the stimulus
  always @(posedge clk) begin : hold_receiver
    if (hold_flip != hold_seen) begin
      hold_seen <= hold_flip;
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic enqueue_word(input logic [1:0] act, input logic [7:0] idx,
                              input logic signed [15:0] x, input logic signed [15:0] y);
    wpc_in_t w;
    w.action = act;
    w.entry_index = idx;
    w.waypoint_x = x;
    w.waypoint_y = y;
    pending_words.push_back(w);
    words_queued++;
    if (act == ACT_LOAD) plan_written[idx] = 1'b1;
  endtask

  // near points sit well inside the reach circle
  function automatic logic signed [15:0] pick_coord(input bit near_origin);
    int half;
    half = int'(cfg_shadow.reach_distance) / 2;
    if (near_origin) return 16'(int'($urandom_range(2 * half)) - half);
    return 16'($urandom);
  endfunction

  task automatic fill_plan(input int len);
    bit near_origin;
    for (int e = 0; e < len; e++) begin
      if (e < 24 || !plan_written[e]) begin
        near_origin = ($urandom_range(99) < 70);
        enqueue_word(ACT_LOAD, 8'(e), pick_coord(near_origin), pick_coord(near_origin));
      end
    end
  endtask

  task automatic wait_idle(input int settle);
    while (words_taken != words_queued || drive_cmds_due.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  task automatic set_config(input logic [15:0] lg, input logic [15:0] ag,
                            input logic [15:0] mhe, input logic [15:0] mls,
                            input logic [15:0] mas, input logic [15:0] rd,
                            input logic [15:0] pl);
    cfg_shadow.linear_gain = lg;
    cfg_shadow.angular_gain = ag;
    cfg_shadow.max_heading_error = mhe[13:0];
    cfg_shadow.max_linear_speed = mls[14:0];
    cfg_shadow.max_angular_speed = mas[14:0];
    cfg_shadow.reach_distance = rd[14:0];
    cfg_shadow.plan_length = pl[8:0];
    write_reg(REG_LINEAR_GAIN, lg);
    write_reg(REG_ANGULAR_GAIN, ag);
    write_reg(REG_MAX_HEADING_ERROR, mhe);
    write_reg(REG_MAX_LINEAR_SPEED, mls);
    write_reg(REG_MAX_ANGULAR_SPEED, mas);
    write_reg(REG_REACH_DISTANCE, rd);
    write_reg(REG_PLAN_LENGTH, pl);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int          n, roll, len_c;
    logic [15:0] lg, ag, mhe, mls, mas, rd, pl;
    logic [7:0]  idx;
    bit          near_origin;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty plan after reset, unused action, index set past the plan
    enqueue_word(ACT_STEP, 8'h00, 16'($urandom), 16'($urandom));
    enqueue_word(ACT_UNUSED, 8'hFF, 16'sh8000, 16'sh7FFF);
    enqueue_word(ACT_SET, 8'd200, 16'h0000, 16'hFFFF);
    enqueue_word(ACT_STEP, 8'h00, 16'($urandom), 16'($urandom));
    wait_idle(40);

    set_config(16'd512, 16'd256, 16'd2048, 16'd51, 16'd256, 16'd26, 16'd8);
    enqueue_word(ACT_LOAD, 8'd0, 16'sd0, 16'sd0);
    enqueue_word(ACT_LOAD, 8'd1, 16'sh8000, 16'sh8000);
    enqueue_word(ACT_LOAD, 8'd2, 16'sh7FFF, 16'sh7FFF);
    enqueue_word(ACT_LOAD, 8'd3, 16'sh8000, 16'sd0);
    enqueue_word(ACT_LOAD, 8'd4, 16'sd0, 16'sh8000);
    enqueue_word(ACT_LOAD, 8'd5, -16'sd1, -16'sd1);
    enqueue_word(ACT_LOAD, 8'd6, 16'sd300, -16'sd20);
    enqueue_word(ACT_LOAD, 8'd7, 16'sh7FFF, 16'sd0);
    enqueue_word(ACT_SET, 8'd0, 16'sd0, 16'sd0);
    enqueue_word(ACT_STEP, 8'd0, 16'sd0, 16'sd0);
    enqueue_word(ACT_STEP, 8'd0, 16'sd0, 16'sd0);
    enqueue_word(ACT_SET, 8'd3, 16'sd0, 16'sd0);
    enqueue_word(ACT_STEP, 8'd0, 16'sd0, 16'sd0);
    enqueue_word(ACT_SET, 8'd5, 16'sd0, 16'sd0);
    enqueue_word(ACT_STEP, 8'd0, 16'sd0, 16'sd0);
    enqueue_word(ACT_STEP, 8'd0, 16'sd0, 16'sd0);
    enqueue_word(ACT_SET, 8'd7, 16'sd0, 16'sd0);
    enqueue_word(ACT_STEP, 8'd0, 16'sd0, 16'sd0);
    enqueue_word(ACT_SET, 8'd8, 16'sd0, 16'sd0);
    enqueue_word(ACT_STEP, 8'd0, 16'sd0, 16'sd0);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle(40);
      if (p < 3) begin
        send_idle_pct = 14;
        recv_stall_pct = 84;
      end else if (p < 6) begin
        send_idle_pct = 84;
        recv_stall_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      lg  = (p == 1) ? 16'd0 : (p == 2) ? 16'hFFFF : 16'($urandom_range(1024));
      ag  = (p == 2) ? 16'd0 : (p == 4) ? 16'hFFFF : 16'($urandom_range(2048));
      mhe = (p == 3) ? 16'd0 : (p == 0 || p == 4) ? 16'd12868
                                                  : 16'($urandom_range(12868));
      mls = (p == 4) ? 16'd0 : (p == 1) ? 16'd32767 : 16'($urandom_range(2048));
      mas = (p == 1) ? 16'd0 : (p == 4) ? 16'd32767 : 16'($urandom_range(4096));
      rd  = (p == 5) ? 16'd0 : (p == 3) ? 16'd32767 : 16'($urandom_range(3000, 16));
      // plan longer than the store, full store, empty plan and a single goal
      pl  = (p == 0) ? 16'd511 : (p == 7) ? 16'd256 : (p == 5) ? 16'd0
          : (p == 8) ? 16'd1 : 16'($urandom_range(16, 2));
      set_config(lg, ag, mhe, mls, mas, rd, pl);
      len_c = (int'(pl) > MAX_WP) ? MAX_WP : int'(pl);
      fill_plan(len_c);
      if (p == 6) hold_flip = ~hold_flip;
      enqueue_word(ACT_SET, 8'd0, 16'($urandom), 16'($urandom));
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        roll = $urandom_range(99);
        if (roll < 62) begin
          enqueue_word(ACT_STEP, 8'($urandom), 16'($urandom), 16'($urandom));
          n++;
        end else if (roll < 76) begin
          idx = (len_c > 0 && $urandom_range(1) == 1) ? 8'($urandom_range(len_c - 1))
                                                      : 8'($urandom_range(255));
          near_origin = ($urandom_range(99) < 60);
          enqueue_word(ACT_LOAD, idx, pick_coord(near_origin), pick_coord(near_origin));
          n++;
        end else if (roll < 92) begin
          idx = (len_c > 0 && $urandom_range(3) != 0) ? 8'($urandom_range(len_c - 1))
                                                      : 8'($urandom_range(255));
          enqueue_word(ACT_SET, idx, 16'($urandom), 16'($urandom));
          n++;
        end else begin
          enqueue_word(ACT_UNUSED, 8'($urandom), 16'($urandom), 16'($urandom));
        end
      end
    end

    wait_idle(60);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
